// File: sv/vfc_pkg.sv
// vfc_pkg: shared types and constants for the voxel face cull unit.
// No dependencies; imported by vfc_ram and voxel_face_cull_unit.
package vfc_pkg;

  localparam int OP_W      = 2;
  localparam int COORD_W   = 4;
  localparam int SEL_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 1;
  localparam int NUM_CFG   = 6;

  localparam logic [OP_W-1:0] OP_WR_VOXEL = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_PLANE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

  localparam logic [SEL_W-1:0] PL_LEFT  = 3'd0;
  localparam logic [SEL_W-1:0] PL_RIGHT = 3'd1;
  localparam logic [SEL_W-1:0] PL_FRONT = 3'd2;
  localparam logic [SEL_W-1:0] PL_BACK  = 3'd3;
  localparam logic [SEL_W-1:0] PL_BELOW = 3'd4;
  localparam logic [SEL_W-1:0] PL_ABOVE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BELOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE = 3'd5;

  // write control of one bit-addressable RAM
  typedef struct packed {
    logic clr;    // zero the whole word at the write address
    logic we;     // write one bit of the word
    logic wdata;
  } ram_ctl_t;

endpackage

// File: sv/vfc_ram.sv
// vfc_ram: word-organized bit RAM, one write port with bit select or word clear,
// two registered read ports. Depends on vfc_pkg.
module vfc_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  vfc_pkg::ram_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [$clog2(WIDTH)-1:0] wbit,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);
  import vfc_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[waddr] <= '0;
    end else if (ctl.we) begin
      mem[waddr][wbit] <= ctl.wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: sv/voxel_face_cull_unit.sv
// voxel_face_cull_unit: voxel cube and boundary plane store with six-face query.
// A query's result passes through the registered RAM reads and the result register.
// Throughput: one word per cycle while busy is low; three cube copies and three
// plane RAMs, two read ports each, deliver every row a query needs in one RAM access.
// Reset: synchronous; busy stays high while all RAMs are cleared row by row.
// Results cannot be stalled.
module voxel_face_cull_unit #(
  parameter int EDGE = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [vfc_pkg::OP_W-1:0]          in_operation,
  input  logic [vfc_pkg::COORD_W-1:0]       in_pos_x,
  input  logic [vfc_pkg::COORD_W-1:0]       in_pos_y,
  input  logic [vfc_pkg::COORD_W-1:0]       in_pos_z,
  input  logic [vfc_pkg::SEL_W-1:0]         in_plane_sel,
  input  logic                              in_visible_in,
  output logic                              out_valid,
  output logic                              out_face_left,
  output logic                              out_face_right,
  output logic                              out_face_down,
  output logic                              out_face_up,
  output logic                              out_face_front,
  output logic                              out_face_back,
  input  logic                              cfg_we,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vfc_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import vfc_pkg::*;

  localparam int CW    = $clog2(EDGE);
  localparam int CDEP  = EDGE * EDGE;
  localparam int AW    = $clog2(CDEP);
  localparam int PDEP  = 2 * EDGE;
  localparam int PAW   = $clog2(PDEP);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  logic left_r, right_r, front_r, back_r, below_r, above_r;

  // ---------------- clear sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AW'(CDEP - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r;
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  logic clearing;
  assign clearing = (state_r == ST_CLEAR);
  assign busy     = clearing;

  // ---------------- config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 1'b0;
      right_r <= 1'b0;
      front_r <= 1'b0;
      back_r  <= 1'b0;
      below_r <= 1'b0;
      above_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT:  left_r  <= cfg_data[0];
        CFG_RIGHT: right_r <= cfg_data[0];
        CFG_FRONT: front_r <= cfg_data[0];
        CFG_BACK:  back_r  <= cfg_data[0];
        CFG_BELOW: below_r <= cfg_data[0];
        CFG_ABOVE: above_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: decode and RAM access
  logic          acc;
  logic          x_ok, y_ok, z_ok;
  logic [CW-1:0] xi, yi, zi, xm, xp, ym, yp;

  assign acc  = start && !busy;
  assign x_ok = (32'(in_pos_x) < EDGE);
  assign y_ok = (32'(in_pos_y) < EDGE);
  assign z_ok = (32'(in_pos_z) < EDGE);
  assign xi   = CW'(in_pos_x);
  assign yi   = CW'(in_pos_y);
  assign zi   = CW'(in_pos_z);
  assign xm   = (xi != '0) ? xi - 1'b1 : xi;
  assign ym   = (yi != '0) ? yi - 1'b1 : yi;
  assign xp   = (32'(xi) < EDGE - 1) ? xi + 1'b1 : xi;
  assign yp   = (32'(yi) < EDGE - 1) ? yi + 1'b1 : yi;

  logic [AW-1:0] a_ctr, a_xm, a_xp, a_ym, a_yp;
  assign a_ctr = AW'(32'(xi) * EDGE + 32'(yi));
  assign a_xm  = AW'(32'(xm) * EDGE + 32'(yi));
  assign a_xp  = AW'(32'(xp) * EDGE + 32'(yi));
  assign a_ym  = AW'(32'(xi) * EDGE + 32'(ym));
  assign a_yp  = AW'(32'(xi) * EDGE + 32'(yp));

  logic cube_we, plane_we;
  assign cube_we  = acc && (in_operation == OP_WR_VOXEL) && x_ok && y_ok && z_ok;
  assign plane_we = acc && (in_operation == OP_WR_PLANE) && x_ok && y_ok;

  logic lr_sel, fb_sel, du_sel;
  always_comb begin
    lr_sel = in_plane_sel inside {PL_LEFT, PL_RIGHT};
    fb_sel = in_plane_sel inside {PL_FRONT, PL_BACK};
    du_sel = in_plane_sel inside {PL_BELOW, PL_ABOVE};
  end

  ram_ctl_t      cube_ctl, lr_ctl, fb_ctl, du_ctl;
  logic [AW-1:0] cube_waddr;
  logic [CW-1:0] cube_wbit;
  logic [PAW-1:0] p_waddr;
  logic           p_clr;

  assign p_clr = clearing && (32'(cnt_r) < PDEP);

  always_comb begin
    cube_ctl.clr   = clearing;
    cube_ctl.we    = cube_we;
    cube_ctl.wdata = in_visible_in;
    cube_waddr     = clearing ? cnt_r : a_ctr;
    cube_wbit      = zi;

    p_waddr = clearing ? PAW'(cnt_r)
            : (in_plane_sel[0] ? PAW'(EDGE + 32'(xi)) : PAW'(xi));

    lr_ctl.clr   = p_clr;
    lr_ctl.we    = plane_we && lr_sel;
    lr_ctl.wdata = in_visible_in;
    fb_ctl.clr   = p_clr;
    fb_ctl.we    = plane_we && fb_sel;
    fb_ctl.wdata = in_visible_in;
    du_ctl.clr   = p_clr;
    du_ctl.we    = plane_we && du_sel;
    du_ctl.wdata = in_visible_in;
  end

  logic [EDGE-1:0] ca_ctr, ca_xm, cb_xp, cb_ym, cc_yp, cc_ctr;
  logic [EDGE-1:0] p_left, p_right, p_front, p_back, p_below, p_above;

  vfc_ram #(.DEPTH(CDEP), .WIDTH(EDGE)) u_cube_a (
    .clk(clk), .ctl(cube_ctl), .waddr(cube_waddr), .wbit(cube_wbit),
    .raddr0(a_ctr), .raddr1(a_xm), .rdata0(ca_ctr), .rdata1(ca_xm)
  );

  vfc_ram #(.DEPTH(CDEP), .WIDTH(EDGE)) u_cube_b (
    .clk(clk), .ctl(cube_ctl), .waddr(cube_waddr), .wbit(cube_wbit),
    .raddr0(a_xp), .raddr1(a_ym), .rdata0(cb_xp), .rdata1(cb_ym)
  );

  vfc_ram #(.DEPTH(CDEP), .WIDTH(EDGE)) u_cube_c (
    .clk(clk), .ctl(cube_ctl), .waddr(cube_waddr), .wbit(cube_wbit),
    .raddr0(a_yp), .raddr1(a_ctr), .rdata0(cc_yp), .rdata1(cc_ctr)
  );

  vfc_ram #(.DEPTH(PDEP), .WIDTH(EDGE)) u_plane_lr (
    .clk(clk), .ctl(lr_ctl), .waddr(p_waddr), .wbit(yi),
    .raddr0(PAW'(yi)), .raddr1(PAW'(EDGE + 32'(yi))),
    .rdata0(p_left), .rdata1(p_right)
  );

  vfc_ram #(.DEPTH(PDEP), .WIDTH(EDGE)) u_plane_fb (
    .clk(clk), .ctl(fb_ctl), .waddr(p_waddr), .wbit(yi),
    .raddr0(PAW'(xi)), .raddr1(PAW'(EDGE + 32'(xi))),
    .rdata0(p_front), .rdata1(p_back)
  );

  vfc_ram #(.DEPTH(PDEP), .WIDTH(EDGE)) u_plane_du (
    .clk(clk), .ctl(du_ctl), .waddr(p_waddr), .wbit(yi),
    .raddr0(PAW'(xi)), .raddr1(PAW'(EDGE + 32'(xi))),
    .rdata0(p_below), .rdata1(p_above)
  );

  // ---------------- stage 1: face logic
  logic          q_r, ok_r;
  logic [CW-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= acc && (in_operation == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= x_ok && y_ok && z_ok;
    x_r  <= xi;
    y_r  <= yi;
    z_r  <= zi;
  end

  logic          hit, x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  logic [CW-1:0] zm, zp;
  logic          f_left, f_right, f_down, f_up, f_front, f_back;

  assign x_lo = (x_r == '0);
  assign y_lo = (y_r == '0);
  assign z_lo = (z_r == '0);
  assign x_hi = (x_r == CW'(EDGE - 1));
  assign y_hi = (y_r == CW'(EDGE - 1));
  assign z_hi = (z_r == CW'(EDGE - 1));
  assign zm   = z_lo ? z_r : z_r - 1'b1;
  assign zp   = z_hi ? z_r : z_r + 1'b1;
  assign hit  = ok_r && ca_ctr[z_r];

  always_comb begin
    f_left  = hit && (x_lo ? (left_r && !p_left[z_r])   : !ca_xm[z_r]);
    f_right = hit && (x_hi ? (right_r && !p_right[z_r]) : !cb_xp[z_r]);
    f_down  = hit && (y_lo ? (below_r && !p_below[z_r]) : !cb_ym[z_r]);
    f_up    = hit && (y_hi ? (!above_r || !p_above[z_r]) : !cc_yp[z_r]);
    f_front = hit && (z_lo ? (front_r && !p_front[y_r]) : !cc_ctr[zm]);
    f_back  = hit && (z_hi ? (back_r && !p_back[y_r])   : !cc_ctr[zp]);
  end

  // ---------------- result register
  logic out_valid_r;
  logic fl_r, fr_r, fd_r, fu_r, ff_r, fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_r;
    end
  end

  always_ff @(posedge clk) begin
    fl_r <= f_left;
    fr_r <= f_right;
    fd_r <= f_down;
    fu_r <= f_up;
    ff_r <= f_front;
    fb_r <= f_back;
  end

  assign out_valid      = out_valid_r;
  assign out_face_left  = fl_r;
  assign out_face_right = fr_r;
  assign out_face_down  = fd_r;
  assign out_face_up    = fu_r;
  assign out_face_front = ff_r;
  assign out_face_back  = fb_r;

  // ---------------- checks
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_operation == OP_QUERY), 2))
    else $error("result word without a matching query");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("clear pass restarted without reset");

  a_no_result_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result word during clear pass");

endmodule
